// ===== hdl/encoder_blind_position_controller_top_macros.svh =====
// ----------------------------------------------------------------------------
// encoder_blind_position_controller_top_macros
// Assertion macros shared by the blind position controller RTL.
// ----------------------------------------------------------------------------
`ifndef ENCODER_BLIND_POSITION_CONTROLLER_TOP_MACROS_SVH
`define ENCODER_BLIND_POSITION_CONTROLLER_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS

// antecedent implies consequent in the same cycle
`define EBPC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("ebpc assertion failed");

// antecedent implies consequent in the next cycle
`define EBPC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("ebpc assertion failed");

`else

`define EBPC_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define EBPC_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== hdl/ebpc_pkg.sv =====
// ----------------------------------------------------------------------------
// ebpc_pkg
// Types and constants of the encoder blind position controller.
// ----------------------------------------------------------------------------
package ebpc_pkg;

	localparam int POSITION_BITS_DEF = 16;

	localparam logic [6:0]  PERCENT_FULL = 7'd100;
	localparam logic [14:0] TRAVEL_RESET = 15'd3000;
	localparam logic [14:0] TRAVEL_MAX   = 15'd32767;

	// travel * percent fits in 22 bits; x / 100 = (x * ceil(2^29 / 100)) >> 29
	localparam int          PROD_W       = 22;
	localparam int          RECIP_W      = 23;
	localparam int          RECIP_SHIFT  = 29;
	localparam logic [22:0] RECIP_100    = 23'd5368710;

	typedef enum logic [1:0] {
		PH_00 = 2'b00,
		PH_01 = 2'b01,
		PH_10 = 2'b10,
		PH_11 = 2'b11
	} ebpc_phase_t;

	typedef enum logic [1:0] {
		MODE_IDLE,
		MODE_MOVE,
		MODE_CAL_HOME,
		MODE_CAL_CLOSE
	} ebpc_mode_t;

	typedef struct packed {
		logic       encoder_b;
		logic       limit_button;
		logic       move_request;
		logic [6:0] move_percent;
		logic       calibrate_request;
	} ebpc_in_t;

	typedef struct packed {
		logic               drive_close;
		logic               drive_open;
		logic signed [15:0] position;
		logic [14:0]        full_travel;
		logic               busy_res;
	} ebpc_out_t;

endpackage

// ===== hdl/ebpc_encoder.sv =====
// ----------------------------------------------------------------------------
// ebpc_encoder
// Encoder phase machine with saturating up/down position count.
// ----------------------------------------------------------------------------
module ebpc_encoder import ebpc_pkg::*; #(
	parameter int POSITION_BITS = POSITION_BITS_DEF
) (
	input  ebpc_phase_t                     phase,
	input  logic                            encoder_b,
	input  logic                            closing,
	input  logic signed [POSITION_BITS-1:0] pos,
	output ebpc_phase_t                     phase_nxt,
	output logic signed [POSITION_BITS-1:0] pos_nxt
);

	localparam logic signed [POSITION_BITS-1:0] POS_MAX = {1'b0, {(POSITION_BITS-1){1'b1}}};
	localparam logic signed [POSITION_BITS-1:0] POS_MIN = {1'b1, {(POSITION_BITS-1){1'b0}}};

	always_comb begin
		phase_nxt = phase;
		pos_nxt   = pos;
		unique case (phase)
			PH_00: begin
				if (encoder_b) begin
					phase_nxt = PH_11;
				end
			end
			PH_10: begin
				phase_nxt = PH_00;
			end
			PH_11: begin
				// falling edge of b after a high phase counts one step
				if (!encoder_b) begin
					phase_nxt = PH_00;
					if (closing) begin
						if (pos != POS_MAX) begin
							pos_nxt = pos + POSITION_BITS'(1);
						end
					end else begin
						if (pos != POS_MIN) begin
							pos_nxt = pos - POSITION_BITS'(1);
						end
					end
				end
			end
			PH_01: begin
				phase_nxt = PH_11;
			end
			default: begin
				phase_nxt = PH_00;
			end
		endcase
	end

endmodule

// ===== hdl/encoder_blind_position_controller_top.sv =====
// ----------------------------------------------------------------------------
// encoder_blind_position_controller_top
// Bang-bang blind controller: counts encoder steps, drives to a percentage
// of the calibrated travel and runs the home / limit calibration.
//
//   channel   signals                      payload
//   in        in_valid / in_ready          in_data  (ebpc_in_t)
//   out       out_valid / out_ready        out_data (ebpc_out_t)
//
// One item per cycle unless the output stalls.
// The travel * percent product is formed at accept, the divide by 100 and
// the controller update run in the input stage before the result register.
// A stalled output holds the input stage; the input side keeps taking items
// until both stages are full. Reset clears controller state and valid flags.
// ----------------------------------------------------------------------------
`include "encoder_blind_position_controller_top_macros.svh"

module encoder_blind_position_controller_top import ebpc_pkg::*; #(
	parameter int POSITION_BITS = POSITION_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  ebpc_in_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output ebpc_out_t out_data
);

	localparam int CW = (POSITION_BITS > 16) ? POSITION_BITS : 16;
	localparam logic signed [CW-1:0] TRAVEL_MAX_EXT = CW'(TRAVEL_MAX);
	localparam logic signed [CW-1:0] ZERO_EXT       = '0;

	// state
	ebpc_phase_t                     phase_q;
	logic signed [POSITION_BITS-1:0] pos_q;
	logic [14:0]                     travel_q;
	logic                            dir_q;
	logic signed [CW-1:0]            tgt_q;
	ebpc_mode_t                      mode_q;

	// pipeline
	logic                 valid_s1;
	ebpc_in_t             item_s1;
	logic [PROD_W-1:0]    prod_s1;
	logic                 out_valid_q;
	ebpc_out_t            out_q;

	logic advance, step, accept;

	ebpc_phase_t                     phase_nxt;
	logic signed [POSITION_BITS-1:0] pos_nxt;
	logic signed [CW-1:0]            pos_ext;
	logic signed [CW-1:0]            tgt_nxt;
	logic signed [CW-1:0]            tgt_move;
	logic [14:0]                     travel_nxt;
	logic [14:0]                     travel_clamp;
	logic [14:0]                     travel_fwd;
	logic [6:0]                      pct_clamp;
	logic [PROD_W+RECIP_W-1:0]       quot_full;
	logic                            dir_nxt;
	logic                            reached;
	logic                            driving;
	ebpc_mode_t                      mode_nxt;

	assign advance  = !out_valid_q || out_ready;
	assign step     = valid_s1 && advance;
	assign in_ready = !valid_s1 || advance;
	assign accept   = in_valid && in_ready;

	ebpc_encoder #(
		.POSITION_BITS(POSITION_BITS)
	) u_encoder (
		.phase     (phase_q),
		.encoder_b (item_s1.encoder_b),
		.closing   (dir_q),
		.pos       (pos_q),
		.phase_nxt (phase_nxt),
		.pos_nxt   (pos_nxt)
	);

	assign pos_ext = CW'(pos_nxt);

	// divide by 100 through the reciprocal
	assign quot_full = prod_s1 * RECIP_100;
	assign tgt_move  = CW'({1'b0, quot_full[RECIP_SHIFT +: 15]});

	always_comb begin
		if (pos_ext < ZERO_EXT) begin
			travel_clamp = '0;
		end else if (pos_ext > TRAVEL_MAX_EXT) begin
			travel_clamp = TRAVEL_MAX;
		end else begin
			travel_clamp = pos_ext[14:0];
		end
	end

	assign reached = dir_q ? (pos_ext >= tgt_q) : (pos_ext <= tgt_q);

	always_comb begin
		mode_nxt   = mode_q;
		dir_nxt    = dir_q;
		tgt_nxt    = tgt_q;
		travel_nxt = travel_q;
		unique case (mode_q)
			MODE_MOVE: begin
				if (reached) begin
					mode_nxt = MODE_IDLE;
				end
			end
			MODE_CAL_HOME: begin
				if (reached) begin
					if (item_s1.limit_button) begin
						dir_nxt  = 1'b1;
						mode_nxt = MODE_CAL_CLOSE;
					end else begin
						mode_nxt = MODE_IDLE;
					end
				end
			end
			MODE_CAL_CLOSE: begin
				if (!item_s1.limit_button) begin
					travel_nxt = travel_clamp;
					mode_nxt   = MODE_IDLE;
				end
			end
			MODE_IDLE: begin
				priority if (item_s1.calibrate_request) begin
					tgt_nxt = ZERO_EXT;
					if (ZERO_EXT > pos_ext) begin
						dir_nxt  = 1'b1;
						mode_nxt = MODE_CAL_HOME;
					end else if (ZERO_EXT < pos_ext) begin
						dir_nxt  = 1'b0;
						mode_nxt = MODE_CAL_HOME;
					end else if (item_s1.limit_button) begin
						// already home with the button held
						dir_nxt  = 1'b1;
						mode_nxt = MODE_CAL_CLOSE;
					end
				end else if (item_s1.move_request) begin
					tgt_nxt = tgt_move;
					if (tgt_move > pos_ext) begin
						dir_nxt  = 1'b1;
						mode_nxt = MODE_MOVE;
					end else if (tgt_move < pos_ext) begin
						dir_nxt  = 1'b0;
						mode_nxt = MODE_MOVE;
					end
				end
			end
			default: begin
				mode_nxt = MODE_IDLE;
			end
		endcase
	end

	assign driving = (mode_nxt != MODE_IDLE);

	// travel seen by the item entering the input stage
	assign travel_fwd = step ? travel_nxt : travel_q;
	assign pct_clamp  = (in_data.move_percent > PERCENT_FULL) ? PERCENT_FULL
	                                                          : in_data.move_percent;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_00;
			pos_q    <= '0;
			travel_q <= TRAVEL_RESET;
			dir_q    <= 1'b1;
			tgt_q    <= '0;
			mode_q   <= MODE_IDLE;
		end else if (step) begin
			phase_q  <= phase_nxt;
			pos_q    <= pos_nxt;
			travel_q <= travel_nxt;
			dir_q    <= dir_nxt;
			tgt_q    <= tgt_nxt;
			mode_q   <= mode_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (advance) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= in_data;
			prod_s1 <= PROD_W'(travel_fwd) * PROD_W'(pct_clamp);
		end
		if (step) begin
			out_q.drive_close <= driving && dir_nxt;
			out_q.drive_open  <= driving && !dir_nxt;
			out_q.position    <= pos_ext[15:0];
			out_q.full_travel <= travel_nxt;
			out_q.busy_res    <= driving;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	`EBPC_ASSERT_IMP(a_busy_matches_drive, clk, arst_n, out_valid, out_data.busy_res == (out_data.drive_close || out_data.drive_open))
	`EBPC_ASSERT_NXT(a_travel_only_on_cal, clk, arst_n, !(step && mode_q == MODE_CAL_CLOSE), $stable(travel_q))
	`EBPC_ASSERT_IMP(a_phase_reachable, clk, arst_n, 1'b1, phase_q == PH_00 || phase_q == PH_11)
	`EBPC_ASSERT_NXT(a_state_holds_on_stall, clk, arst_n, !step, $stable(pos_q) && $stable(mode_q))

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the encoder blind position controller. Ticks carry
// encoder B, the limit button and move / calibrate requests. A behavioral
// model predicts drive lines, position, full travel and busy for every tick,
// and each result transfer is compared field by field. A short directed run
// is followed by random move and calibration sequences with idle and stall
// bursts on both channels. A final gap-free run steps the encoder and ends
// with a move to full travel.
// ----------------------------------------------------------------------------
module tb_top;
	import ebpc_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int STALL_LIMIT = 2000;
	localparam int RANDOM_TICKS = 1900;

	typedef struct {
		ebpc_phase_t        phase;
		logic signed [15:0] pos;
		logic [14:0]        travel;
		logic               closing;
		logic signed [15:0] target;
		ebpc_mode_t         mode;
	} blind_state_t;

	typedef struct {
		ebpc_in_t d;
		bit       calm;
		bit       hold;
	} tick_entry_t;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      in_valid = 1'b0;
	logic      in_ready;
	ebpc_in_t  in_data = '0;
	logic      out_valid;
	logic      out_ready = 1'b0;
	ebpc_out_t out_data;

	tick_entry_t  tick_q[$];
	ebpc_out_t    due_status_q[$];
	tick_entry_t  next_tick;
	blind_state_t plan_model;
	blind_state_t ctl_model;
	ebpc_mode_t   mode_was;
	ebpc_out_t    want;
	bit           calm = 1'b0;
	int           burst_odds = 4;
	int           gap_left;
	int           stall_left;
	int           cycle_cnt;
	int           stuck_cycles;
	int           mismatches;
	int           checked;
	int           travel_stores;
	int           pos_lo;
	int           pos_hi;

	encoder_blind_position_controller_top DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	initial forever #10 clk = ~clk;

	function automatic blind_state_t blind_reset();
		blind_state_t s;
		s.phase = PH_00;
		s.pos = '0;
		s.travel = TRAVEL_RESET;
		s.closing = 1'b1;
		s.target = '0;
		s.mode = MODE_IDLE;
		return s;
	endfunction

	// one tick: encoder count first with the old direction, then the controller
	function automatic ebpc_out_t blind_tick(inout blind_state_t s, input ebpc_in_t d);
		ebpc_out_t          o;
		logic               reached;
		logic               at_home;
		logic               aiming;
		logic               go;
		logic [6:0]         pct;
		logic [21:0]        prod;
		logic [21:0]        quo;
		logic signed [15:0] want_pos;

		case (s.phase)
			PH_00: if (d.encoder_b) s.phase = PH_11;
			PH_10: s.phase = PH_00;
			PH_11: begin
				if (!d.encoder_b) begin
					s.phase = PH_00;
					if (s.closing) begin
						if (s.pos != 16'sh7fff) s.pos = s.pos + 16'sd1;
					end else if (s.pos != 16'sh8000) begin
						s.pos = s.pos - 16'sd1;
					end
				end
			end
			default: s.phase = PH_11;
		endcase

		reached = s.closing ? (s.pos >= s.target) : (s.pos <= s.target);
		at_home = 1'b0;
		aiming = 1'b0;
		want_pos = '0;

		case (s.mode)
			MODE_MOVE: if (reached) s.mode = MODE_IDLE;
			MODE_CAL_HOME: at_home = reached;
			MODE_CAL_CLOSE: begin
				if (!d.limit_button) begin
					s.travel = (s.pos < 0) ? 15'd0 : s.pos[14:0];
					s.mode = MODE_IDLE;
				end
			end
			default: begin
				s.mode = MODE_IDLE;
				if (d.calibrate_request) begin
					aiming = 1'b1;
				end else if (d.move_request) begin
					pct = (d.move_percent > PERCENT_FULL) ? PERCENT_FULL : d.move_percent;
					prod = 22'(s.travel) * 22'(pct);
					quo = prod / 22'(PERCENT_FULL);
					want_pos = $signed({1'b0, quo[14:0]});
					aiming = 1'b1;
				end
			end
		endcase

		if (aiming) begin
			s.target = want_pos;
			go = 1'b1;
			if (want_pos > s.pos) s.closing = 1'b1;
			else if (want_pos < s.pos) s.closing = 1'b0;
			else go = 1'b0;
			if (d.calibrate_request) begin
				if (go) s.mode = MODE_CAL_HOME;
				else at_home = 1'b1;
			end else if (go) begin
				s.mode = MODE_MOVE;
			end
		end

		if (at_home) begin
			if (d.limit_button) begin
				s.closing = 1'b1;
				s.mode = MODE_CAL_CLOSE;
			end else begin
				s.mode = MODE_IDLE;
			end
		end

		o.busy_res = s.mode != MODE_IDLE;
		o.drive_close = o.busy_res && s.closing;
		o.drive_open = o.busy_res && !s.closing;
		o.position = s.pos;
		o.full_travel = s.travel;
		return o;
	endfunction

	function automatic ebpc_in_t make_tick(bit b, bit button, bit mv, logic [6:0] pct, bit cal);
		ebpc_in_t d;
		d.encoder_b = b;
		d.limit_button = button;
		d.move_request = mv;
		d.move_percent = pct;
		d.calibrate_request = cal;
		return d;
	endfunction

	function automatic ebpc_in_t noise_tick();
		logic [$bits(ebpc_in_t)-1:0] raw;
		raw = $bits(ebpc_in_t)'($urandom);
		return raw;
	endfunction

	// the plan model follows the queued ticks so sequences can react to state
	task automatic queue_tick(input ebpc_in_t d, input bit calm_part, input bit hold);
		tick_entry_t e;
		void'(blind_tick(plan_model, d));
		e.d = d;
		e.calm = calm_part;
		e.hold = hold;
		tick_q.push_back(e);
	endtask

	task automatic half_step(input bit button, input bit calm_part);
		queue_tick(make_tick(plan_model.phase == PH_00, button, 0, '0, 0), calm_part, 0);
	endtask

	initial begin : stimulus
		int         rand_ticks;
		int         r;
		int         close_left;
		bit         hold_button;
		bit         hold;
		bit         b;
		bit         btn;
		ebpc_in_t   d;
		logic [6:0] pct;

		plan_model = blind_reset();
		rand_ticks = 0;
		close_left = 0;
		hold_button = 1'b0;

		// calibrate at home with the button released: ends at once
		queue_tick(make_tick(0, 0, 0, '0, 1), 0, 0);
		// move to zero percent while already there: no drive
		queue_tick(make_tick(0, 0, 1, '0, 0), 0, 0);
		// both requests: calibrate wins, button held so the close starts
		queue_tick(make_tick(0, 1, 1, 7'h7f, 1), 0, 0);
		for (int i = 0; i < 5; i++) begin
			queue_tick(make_tick(1, 1, i == 2, 7'h7f, i == 3), 0, 0);
			queue_tick(make_tick(0, 1, 0, '0, 0), 0, 0);
		end
		// single low sample stores the travel
		queue_tick(make_tick(0, 0, 0, '0, 0), 0, 0);
		// percent above full clamps: target equals the position
		queue_tick(make_tick(0, 0, 1, 7'd127, 0), 0, 0);
		queue_tick(make_tick(0, 0, 1, 7'd40, 0), 0, 0);
		while (plan_model.mode != MODE_IDLE) half_step(0, 0);

		while (rand_ticks < RANDOM_TICKS) begin
			hold = 1'b0;
			if (plan_model.mode == MODE_IDLE) begin
				hold = (rand_ticks == 0) || ($urandom_range(0, 49) == 0);
				r = $urandom_range(0, 99);
				if (r < 12) begin
					d = noise_tick();
				end else if (r < 22) begin
					d = make_tick(plan_model.phase == PH_00, 1'($urandom_range(0, 1)), 0,
						'0, 0);
				end else if (r < 45) begin
					hold_button = $urandom_range(0, 3) != 0;
					close_left = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 300)
						: $urandom_range(0, 40);
					d = make_tick(1'($urandom_range(0, 1)), hold_button,
						1'($urandom_range(0, 1)), 7'($urandom), 1);
				end else begin
					pct = ($urandom_range(0, 9) == 0) ? 7'($urandom_range(101, 127))
						: 7'($urandom_range(0, 100));
					d = make_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1,
						pct, 0);
				end
			end else if ($urandom_range(0, 11) == 0) begin
				d = noise_tick();
			end else begin
				b = plan_model.phase == PH_00;
				// sometimes linger on a level for a longer half period
				if ($urandom_range(0, 4) == 0) b = !b;
				case (plan_model.mode)
					MODE_CAL_CLOSE: btn = close_left != 0;
					MODE_CAL_HOME: btn = hold_button;
					default: btn = 1'($urandom_range(0, 1));
				endcase
				if (plan_model.mode == MODE_CAL_CLOSE && plan_model.phase == PH_11 && !b
						&& close_left != 0)
					close_left--;
				d = make_tick(b, btn, 0, '0, 0);
				// stray requests while busy are ignored
				if ($urandom_range(0, 3) == 0) begin
					d.move_request = 1'($urandom_range(0, 1));
					d.calibrate_request = 1'($urandom_range(0, 1));
					d.move_percent = 7'($urandom);
				end
			end
			queue_tick(d, 0, hold);
			rand_ticks++;
		end

		// gap-free tail: settle, step the encoder, then move to full travel
		queue_tick(make_tick(0, 0, 0, '0, 0), 1, 1);
		while (plan_model.mode != MODE_IDLE) half_step(0, 1);
		repeat (40) half_step(0, 1);
		queue_tick(make_tick(0, 0, 1, PERCENT_FULL, 0), 1, 0);
		while (plan_model.mode != MODE_IDLE) half_step(0, 1);

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		do @(posedge clk);
		while (tick_q.size() != 0 || in_valid || due_status_q.size() != 0);
		repeat (8) @(posedge clk);

		$display("summary: %0d results checked, %0d travel calibrations stored", checked,
			travel_stores);
		$display("summary: position swept from %0d to %0d", pos_lo, pos_hi);
		if (mismatches == 0) begin
			$display("tb_top: clean");
		end else begin
			$display("tb_top: errors");
		end
		$finish;
	end

	// sender
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data <= '0;
			gap_left = 0;
		end else if (!in_valid || in_ready) begin
			if (gap_left != 0) begin
				gap_left--;
				in_valid <= 1'b0;
			end else if (tick_q.size() == 0) begin
				in_valid <= 1'b0;
			end else if (tick_q[0].hold && (in_valid || due_status_q.size() != 0)) begin
				// hold off until every result in flight has been seen
				in_valid <= 1'b0;
			end else if (!calm && burst_odds != 0 && $urandom_range(1, burst_odds) == 1) begin
				gap_left = $urandom_range(0, 7);
				in_valid <= 1'b0;
			end else begin
				next_tick = tick_q.pop_front();
				in_data <= next_tick.d;
				in_valid <= 1'b1;
				if (next_tick.calm) calm <= 1'b1;
			end
		end
	end

	// predictor, checker and receiver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			stall_left = 0;
			cycle_cnt = 0;
			ctl_model = blind_reset();
		end else begin
			cycle_cnt++;
			if (cycle_cnt % 300 == 0) begin
				case ($urandom_range(0, 2))
					0: burst_odds <= 0;
					1: burst_odds <= 4;
					default: burst_odds <= 16;
				endcase
			end

			if (in_valid && in_ready) begin
				mode_was = ctl_model.mode;
				due_status_q.push_back(blind_tick(ctl_model, in_data));
				if (mode_was == MODE_CAL_CLOSE && ctl_model.mode == MODE_IDLE)
					travel_stores++;
				if (ctl_model.pos < pos_lo) pos_lo = ctl_model.pos;
				if (ctl_model.pos > pos_hi) pos_hi = ctl_model.pos;
			end

			if (out_valid && out_ready) begin
				if (due_status_q.size() == 0) begin
					$error("result transfer with nothing expected: position %0d",
						out_data.position);
					mismatches++;
				end else begin
					want = due_status_q.pop_front();
					checked++;
					if (out_data.drive_close !== want.drive_close) begin
						$error("drive_close: expected %0d, got %0d", want.drive_close,
							out_data.drive_close);
						mismatches++;
					end
					if (out_data.drive_open !== want.drive_open) begin
						$error("drive_open: expected %0d, got %0d", want.drive_open,
							out_data.drive_open);
						mismatches++;
					end
					if (out_data.position !== want.position) begin
						$error("position: expected %0d, got %0d", want.position,
							out_data.position);
						mismatches++;
					end
					if (out_data.full_travel !== want.full_travel) begin
						$error("full_travel: expected %0d, got %0d", want.full_travel,
							out_data.full_travel);
						mismatches++;
					end
					if (out_data.busy_res !== want.busy_res) begin
						$error("busy_res: expected %0d, got %0d", want.busy_res,
							out_data.busy_res);
						mismatches++;
					end
				end
			end

			if (stall_left != 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else if (!calm && burst_odds != 0 && $urandom_range(1, burst_odds) == 1) begin
				stall_left = $urandom_range(0, 7);
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				stuck_cycles <= 0;
			end else if (stuck_cycles >= STALL_LIMIT) begin
				$display("tb_top: errors");
				$finish;
			end else begin
				stuck_cycles <= stuck_cycles + 1;
			end
		end
	end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/ebpc_pkg.sv
hdl/ebpc_encoder.sv
hdl/encoder_blind_position_controller_top.sv
tb/tb_top.sv
